### rtl/core/ppgpk_pkg.sv
package ppgpk_pkg;

    localparam int unsigned RING_DEPTH_DEF   = 64;
    localparam int unsigned RMSSD_WINDOW_DEF = 32;
    localparam logic [15:0] SAT16            = 16'hFFFF;
    localparam logic [19:0] SAT20            = 20'hFFFFF;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_INIT_THR = 2'd0,
        REG_MIN_INT  = 2'd1,
        REG_MAX_INT  = 2'd2,
        REG_REFRACT  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

### rtl/core/ppg_peak_rr_interval_rmssd_core.sv
// PPG peak detector with peak-to-peak interval ring and RMSSD query.
//
// Input channel (s_valid/s_ready): one transaction per item. Opcode OP_SAMPLE
// feeds one signed sample with its millisecond timestamp; OP_QUERY asks for the
// RMSSD of the newest RMSSD_WINDOW stored intervals.
// Result channel (m_valid/m_ready): exactly one result transaction per item,
// held in an output register until taken.
// Processing: a sample item is resolved as it is accepted; its result is shown
// the next cycle. A query walks the n = min(stored, RMSSD_WINDOW) newest
// entries of the interval memory one entry per cycle (one synchronous read
// port), then runs a restoring divider over 45 quotient bits and a bit-pair
// square root over 23 steps. One item is worked on at a time; a new item is
// taken once the previous result is in the output register and that register
// is free or being drained.
// Reset (aresetn, synchronous, low): registers return to their reset values,
// the threshold takes the start threshold register, the ring is empty. Ring
// contents are not cleared; only written entries are ever read.
// Receiver stall: the result register holds; the block accepts no new item
// until it can deliver.
// APB port: registers at 0x0,0x4,0x8,0xC; the user writes only while idle (not enforced by the block).
module ppg_peak_rr_interval_rmssd_core
    import ppgpk_pkg::*;
#(
    parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF,
    parameter int unsigned RMSSD_WINDOW = RMSSD_WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic signed [23:0] s_sample_value,
    input  logic [31:0] s_sample_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_new_interval,
    output logic        m_interval_stored,
    output logic [15:0] m_interval_ms,
    output logic [31:0] m_peak_time_ms,
    output logic [19:0] m_rmssd_value,
    output logic        m_status
);

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam int unsigned WIN_EFF = (RMSSD_WINDOW < RING_DEPTH) ? RMSSD_WINDOW : RING_DEPTH;
    localparam int unsigned NW = $clog2(WIN_EFF + 1);
    // sum of up to WIN-1 squares of 16-bit differences, times 256
    localparam int unsigned SW = 32 + $clog2(WIN_EFF) + 8;
    localparam int unsigned QW = 2 * ((SW + 1) / 2);
    localparam int unsigned RW = QW / 2;
    localparam int unsigned DCW = $clog2(SW + 1);
    localparam int unsigned RCW = $clog2(RW + 1);

    // configuration registers
    logic signed [23:0] init_thr_reg;
    logic [15:0]        min_int_reg, max_int_reg, refr_reg;

    // tracker state
    logic signed [23:0] thr_reg;
    logic [15:0]        refr_left_reg;
    logic               above_reg;
    logic signed [23:0] cand_val_reg;
    logic [31:0]        cand_time_reg;
    logic [31:0]        last_peak_reg;
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;

    // interval memory
    logic [15:0]        ring_mem [RING_DEPTH];
    logic [15:0]        rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [15:0]        mem_wdata;

    state_t             state_reg, state_next;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      rd_cnt_reg, acc_cnt_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [15:0]        prev_reg;
    logic [SW-1:0]      sum_reg;
    logic [SW-1:0]      div_rem_reg, div_q_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [QW-1:0]      sq_x_reg;
    logic [RW-1:0]      sq_res_reg;
    logic [RW+1:0]      sq_rem_reg;
    logic [RCW-1:0]     sq_cnt_reg;

    // output register
    logic               m_valid_reg;
    logic               o_new_reg, o_stored_reg, o_status_reg;
    logic [15:0]        o_int_reg;
    logic [31:0]        o_pt_reg;
    logic [19:0]        o_rms_reg;

    logic cfg_wr, s_fire, out_free;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && out_free;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx_t'(paddr[3:2]))
            REG_INIT_THR: prdata = {{8{init_thr_reg[23]}}, init_thr_reg};
            REG_MIN_INT:  prdata = {16'd0, min_int_reg};
            REG_MAX_INT:  prdata = {16'd0, max_int_reg};
            REG_REFRACT:  prdata = {16'd0, refr_reg};
        endcase
    end

    // sample path (resolved combinationally on accept)
    logic signed [24:0] diff;
    logic signed [24:0] step;
    logic signed [23:0] thr_new;
    logic [31:0]        dt;
    logic [15:0]        rr;
    logic               fall, accept_pk, store_pk, is_sample;
    logic [31:0]        pk_time;

    always_comb begin
        diff    = 25'(s_sample_value) - 25'(thr_reg);
        // divide by 8 truncating toward zero
        step    = (diff < 0) ? -((-diff) >>> 3) : (diff >>> 3);
        thr_new = 24'(25'(thr_reg) + step);
        pk_time = (s_sample_value > cand_val_reg) ? s_sample_time_ms : cand_time_reg;
        dt      = pk_time - last_peak_reg;
        rr      = (dt > 32'(SAT16)) ? SAT16 : dt[15:0];
        is_sample = (opcode_t'(s_opcode) == OP_SAMPLE);
        fall      = is_sample && (refr_left_reg == 16'd0) && above_reg
                    && (s_sample_value <= thr_new);
        accept_pk = fall && (dt >= 32'(min_int_reg));
        store_pk  = accept_pk && (rr >= min_int_reg) && (rr <= max_int_reg);
        mem_we    = s_fire && store_pk;
        mem_waddr = head_reg;
        mem_wdata = rr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_thr_reg <= '0;
            min_int_reg  <= 16'd300;
            max_int_reg  <= 16'd2000;
            refr_reg     <= 16'd50;
            thr_reg      <= '0;
            refr_left_reg <= '0;
            above_reg    <= 1'b0;
            cand_val_reg <= '0;
            cand_time_reg <= '0;
            last_peak_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_INIT_THR: begin
                        init_thr_reg <= pwdata[23:0];
                        thr_reg      <= pwdata[23:0];
                    end
                    REG_MIN_INT: min_int_reg <= pwdata[15:0];
                    REG_MAX_INT: max_int_reg <= pwdata[15:0];
                    REG_REFRACT: refr_reg    <= pwdata[15:0];
                endcase
            end
            if (s_fire && is_sample) begin
                thr_reg <= thr_new;
                if (refr_left_reg != 16'd0) begin
                    refr_left_reg <= refr_left_reg - 16'd1;
                end else if (!above_reg) begin
                    if (s_sample_value > thr_new) begin
                        above_reg     <= 1'b1;
                        cand_val_reg  <= s_sample_value;
                        cand_time_reg <= s_sample_time_ms;
                    end
                end else if (fall) begin
                    above_reg     <= 1'b0;
                    cand_val_reg  <= '0;
                    cand_time_reg <= '0;
                    if (accept_pk) begin
                        last_peak_reg <= pk_time;
                        refr_left_reg <= refr_reg;
                    end
                    if (store_pk) begin
                        head_reg <= (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + AW'(1);
                        if (count_reg != CW'(RING_DEPTH))
                            count_reg <= count_reg + CW'(1);
                    end
                end else if (s_sample_value > cand_val_reg) begin
                    cand_val_reg  <= s_sample_value;
                    cand_time_reg <= s_sample_time_ms;
                end
            end
        end
    end

    // interval memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= ring_mem[mem_raddr];
    end
    assign mem_raddr = rd_ptr_reg;

    // ---------------- query sequencer ----------------
    logic [NW-1:0] n_new;
    logic [AW:0]   start_wide;
    logic signed [16:0] d;
    logic [33:0]   d2;
    logic [SW:0]   div_trial;
    logic [RW+1:0] sq_trial;
    logic [RW+1:0] sq_rem_sh;

    always_comb begin
        n_new = (count_reg < CW'(WIN_EFF)) ? NW'(count_reg) : NW'(WIN_EFF);
        start_wide = (AW+1)'(head_reg) + (AW+1)'(RING_DEPTH) - (AW+1)'(n_new);
        d  = 17'(rd_data_reg) - 17'(prev_reg);
        d2 = 34'(d * d);
        div_trial = {div_rem_reg, div_q_reg[SW-1]} - (SW+1)'(n_reg - NW'(1));
        sq_rem_sh = {sq_rem_reg[RW-1:0], sq_x_reg[QW-1:QW-2]};
        sq_trial  = sq_rem_sh - {sq_res_reg, 2'b01};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && !is_sample && count_reg >= CW'(2)) state_next = ST_RD;
            ST_RD:   state_next = ST_ACC;
            ST_ACC:  if (acc_cnt_reg == n_reg) state_next = ST_DIV;
            ST_DIV:  if (div_cnt_reg == DCW'(SW)) state_next = ST_SQRT;
            ST_SQRT: if (sq_cnt_reg == RCW'(RW)) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                n_reg      <= n_new;
                rd_ptr_reg <= (start_wide >= (AW+1)'(RING_DEPTH))
                              ? AW'(start_wide - (AW+1)'(RING_DEPTH)) : AW'(start_wide);
                rd_cnt_reg <= '0;
                acc_cnt_reg <= '0;
                sum_reg    <= '0;
            end
            ST_RD, ST_ACC: begin
                // issue next read, consume the previous one
                if (rd_cnt_reg != n_reg) begin
                    rd_ptr_reg <= (rd_ptr_reg == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
                    rd_cnt_reg <= rd_cnt_reg + NW'(1);
                end
                if (state_reg == ST_ACC && acc_cnt_reg != n_reg) begin
                    prev_reg    <= rd_data_reg;
                    acc_cnt_reg <= acc_cnt_reg + NW'(1);
                    if (acc_cnt_reg != '0)
                        sum_reg <= sum_reg + SW'(d2);
                end
                if (state_next == ST_DIV) begin
                    div_q_reg   <= {sum_reg[SW-9:0], 8'd0};
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg != DCW'(SW)) begin
                    if (!div_trial[SW]) begin
                        div_rem_reg <= div_trial[SW-1:0];
                        div_q_reg   <= {div_q_reg[SW-2:0], 1'b1};
                    end else begin
                        div_rem_reg <= {div_rem_reg[SW-2:0], div_q_reg[SW-1]};
                        div_q_reg   <= {div_q_reg[SW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                end else begin
                    sq_x_reg   <= QW'(div_q_reg);
                    sq_res_reg <= '0;
                    sq_rem_reg <= '0;
                    sq_cnt_reg <= '0;
                end
            end
            ST_SQRT: begin
                if (sq_cnt_reg != RCW'(RW)) begin
                    sq_x_reg <= {sq_x_reg[QW-3:0], 2'b00};
                    if (!sq_trial[RW+1]) begin
                        sq_rem_reg <= sq_trial;
                        sq_res_reg <= {sq_res_reg[RW-2:0], 1'b1};
                    end else begin
                        sq_rem_reg <= sq_rem_sh;
                        sq_res_reg <= {sq_res_reg[RW-2:0], 1'b0};
                    end
                    sq_cnt_reg <= sq_cnt_reg + RCW'(1);
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire && (is_sample || count_reg < CW'(2))) begin
                m_valid_reg <= 1'b1;
            end else if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && is_sample) begin
            o_new_reg    <= accept_pk;
            o_stored_reg <= store_pk;
            o_int_reg    <= accept_pk ? rr : 16'd0;
            o_pt_reg     <= accept_pk ? pk_time : 32'd0;
            o_rms_reg    <= '0;
            o_status_reg <= 1'b0;
        end else if (s_fire) begin
            o_new_reg    <= 1'b0;
            o_stored_reg <= 1'b0;
            o_int_reg    <= '0;
            o_pt_reg     <= '0;
            o_rms_reg    <= '0;
            o_status_reg <= 1'b1;
        end else if (state_reg == ST_OUT && out_free) begin
            o_new_reg    <= 1'b0;
            o_stored_reg <= 1'b0;
            o_int_reg    <= '0;
            o_pt_reg     <= '0;
            o_rms_reg    <= (sq_res_reg > RW'(SAT20)) ? SAT20 : 20'(sq_res_reg);
            o_status_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_new_interval    = o_new_reg;
    assign m_interval_stored = o_stored_reg;
    assign m_interval_ms     = o_int_reg;
    assign m_peak_time_ms    = o_pt_reg;
    assign m_rmssd_value     = o_rms_reg;
    assign m_status          = o_status_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RING_DEPTH)) else $error("ring count overflow");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_store_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (m_valid && m_new_interval && m_interval_stored))
        else $error("stored interval not reported");
    a_query_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> (n_reg >= NW'(2))) else $error("short window");

endmodule

### bench/ppg_peak_rr_interval_rmssd_core_tb.sv
`timescale 1ns / 1ps

import ppgpk_pkg::*;

typedef struct packed {
    logic        new_interval;
    logic        interval_stored;
    logic [15:0] interval_ms;
    logic [31:0] peak_time_ms;
    logic [19:0] rmssd_value;
    logic        status;
} beat_result_t;

class rr_scoreboard;
    localparam int RING_N = 64;
    localparam int WIN_N  = 32;

    logic [23:0] init_thr;
    logic [15:0] min_iv;
    logic [15:0] max_iv;
    logic [15:0] refr_n;

    int          thr_level;
    logic [15:0] refr_left;
    bit          above;
    int          cand_val;
    logic [31:0] cand_t;
    logic [31:0] last_peak_t;
    logic [15:0] rr_ring [RING_N];
    int          head;
    int          count;

    beat_result_t pending_q[$];
    int           errors;

    function new();
        init_thr    = '0;
        min_iv      = 16'd300;
        max_iv      = 16'd2000;
        refr_n      = 16'd50;
        thr_level   = 0;
        refr_left   = '0;
        above       = 0;
        cand_val    = 0;
        cand_t      = '0;
        last_peak_t = '0;
        head        = 0;
        count       = 0;
        errors      = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
        case (idx)
            REG_INIT_THR: begin
                init_thr  = v[23:0];
                thr_level = $signed(v[23:0]);
            end
            REG_MIN_INT: min_iv = v[15:0];
            REG_MAX_INT: max_iv = v[15:0];
            REG_REFRACT: refr_n = v[15:0];
            default: ;
        endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function logic [15:0] ring_entry(int k);
        return rr_ring[(head + RING_N - count + k) % RING_N];
    endfunction

    // Predict the result of one accepted transaction and queue it.
    function void note_input(opcode_t op, logic signed [23:0] smp, logic [31:0] now);
        beat_result_t    r;
        int              s;
        int              n;
        longint          d;
        longint unsigned sum;
        longint unsigned q;
        logic [31:0]     dt;
        logic [15:0]     rr;
        bit              keep;
        r   = '0;
        s   = smp;
        sum = 0;
        if (op == OP_QUERY) begin
            if (count < 2) begin
                r.status = 1'b1;
            end else begin
                n = (count < WIN_N) ? count : WIN_N;
                for (int k = count - n; k + 1 < count; k++) begin
                    d   = longint'(ring_entry(k + 1)) - longint'(ring_entry(k));
                    sum += longint'(d * d);
                end
                q = int_sqrt((sum * 256) / longint'(n - 1));
                if (q > 64'hFFFFF) q = 64'hFFFFF;
                r.rmssd_value = q[19:0];
            end
            pending_q.push_back(r);
            return;
        end
        thr_level = thr_level + (s - thr_level) / 8;
        if (refr_left > 0) begin
            refr_left = refr_left - 1'b1;
        end else if (!above) begin
            if (s > thr_level) begin
                above    = 1;
                cand_val = s;
                cand_t   = now;
            end
        end else begin
            if (s > cand_val) begin
                cand_val = s;
                cand_t   = now;
            end
            if (s <= thr_level) begin
                dt    = cand_t - last_peak_t;
                above = 0;
                if (dt >= min_iv) begin
                    rr   = (dt > 32'hFFFF) ? 16'hFFFF : dt[15:0];
                    keep = (rr >= min_iv) && (rr <= max_iv);
                    if (keep) begin
                        rr_ring[head] = rr;
                        head          = (head + 1) % RING_N;
                        if (count < RING_N) count++;
                    end
                    last_peak_t       = cand_t;
                    refr_left         = refr_n;
                    r.new_interval    = 1'b1;
                    r.interval_stored = keep;
                    r.interval_ms     = rr;
                    r.peak_time_ms    = cand_t;
                end
                cand_val = 0;
                cand_t   = '0;
            end
        end
        pending_q.push_back(r);
    endfunction

    function void check_result(beat_result_t got);
        beat_result_t want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got.new_interval !== want.new_interval) begin
            $display("%0t: new_interval expected %0d actual %0d",
                     $time, want.new_interval, got.new_interval);
            errors++;
        end
        if (got.interval_stored !== want.interval_stored) begin
            $display("%0t: interval_stored expected %0d actual %0d",
                     $time, want.interval_stored, got.interval_stored);
            errors++;
        end
        if (got.interval_ms !== want.interval_ms) begin
            $display("%0t: interval_ms expected %0d actual %0d",
                     $time, want.interval_ms, got.interval_ms);
            errors++;
        end
        if (got.peak_time_ms !== want.peak_time_ms) begin
            $display("%0t: peak_time_ms expected %h actual %h",
                     $time, want.peak_time_ms, got.peak_time_ms);
            errors++;
        end
        if (got.rmssd_value !== want.rmssd_value) begin
            $display("%0t: rmssd_value expected %h actual %h",
                     $time, want.rmssd_value, got.rmssd_value);
            errors++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
            errors++;
        end
    endfunction
endclass

module ppg_peak_rr_interval_rmssd_core_tb;

    localparam int STALL_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic signed [23:0] s_sample_value;
    logic [31:0] s_sample_time_ms;
    logic        m_valid;
    logic        m_ready;
    logic        m_new_interval;
    logic        m_interval_stored;
    logic [15:0] m_interval_ms;
    logic [31:0] m_peak_time_ms;
    logic [19:0] m_rmssd_value;
    logic        m_status;

    rr_scoreboard sb;

    // Stimulus knobs and counters used by the driver, the result sink and the watchdog.
    bit          no_idle;
    bit          hold_req;
    int          idle_cycles = 0;
    logic [31:0] now_ms;
    int          step_lo;
    int          step_hi;
    int          phase_items;

    ppg_peak_rr_interval_rmssd_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_sample_value    (s_sample_value),
        .s_sample_time_ms  (s_sample_time_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_new_interval    (m_new_interval),
        .m_interval_stored (m_interval_stored),
        .m_interval_ms     (m_interval_ms),
        .m_peak_time_ms    (m_peak_time_ms),
        .m_rmssd_value     (m_rmssd_value),
        .m_status          (m_status)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Push one transaction into the block. Valid stays high across back-to-back
    // items; drop it only when a gap is drawn. Check ready mid-cycle so the
    // accepting edge is known before it arrives.
    task automatic send_item(opcode_t op, logic [23:0] val, logic [31:0] t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_sample_value   <= val;
        s_sample_time_ms <= t;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sb.note_input(op, val, t);
        phase_items++;
    endtask

    // Sample item with the running timestamp advanced by a random step.
    task automatic send_sample(logic [23:0] val);
        now_ms = now_ms + $urandom_range(step_lo, step_hi);
        send_item(OP_SAMPLE, val, now_ms);
    endtask

    // One well-formed pulse: baseline, a rising excursion, then back down.
    task automatic send_beat();
        int nb;
        int np;
        nb = $urandom_range(1, 3);
        np = $urandom_range(1, 3);
        repeat (nb) send_sample(-24'sd20000 - 24'($urandom_range(0, 10000)));
        repeat (np) send_sample(24'($urandom_range(20000, 200000)));
        send_sample(-24'sd30000 - 24'($urandom_range(0, 10000)));
    endtask

    // Wait for the block to drain, then write a register over APB.
    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [23:0] thr, logic [15:0] lo, logic [15:0] hi,
                              logic [15:0] refr);
        write_reg(REG_INIT_THR, {8'h00, thr});
        write_reg(REG_MIN_INT, {16'h0, lo});
        write_reg(REG_MAX_INT, {16'h0, hi});
        write_reg(REG_REFRACT, {16'h0, refr});
    endtask

    // Random traffic: mostly pulses, some queries, some raw noise, and the
    // occasional large time jump for wrap and saturation.
    task automatic run_phase(int n_items);
        int pick;
        phase_items = 0;
        while (phase_items < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_beat();
            end else if (pick < 80) begin
                send_item(OP_QUERY, 24'($urandom), $urandom);
            end else if (pick < 95) begin
                send_sample(24'($urandom));
            end else begin
                now_ms = now_ms + $urandom;
                send_sample(24'($urandom));
            end
        end
    endtask

    // Result sink: random back-pressure plus one long hold-off on request.
    // Capture the result mid-cycle, then take it at the next edge.
    initial begin
        int           stall;
        bit           held;
        beat_result_t got;
        m_ready = 1'b0;
        held    = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (hold_req && !held) begin
                stall = 400;
                held  = 1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            got = {m_new_interval, m_interval_stored, m_interval_ms,
                   m_peak_time_ms, m_rmssd_value, m_status};
            @(posedge aclk);
            sb.check_result(got);
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        sb               = new();
        no_idle          = 0;
        hold_req         = 0;
        now_ms           = '0;
        step_lo          = 50;
        step_hi          = 250;
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_opcode         = OP_SAMPLE;
        s_sample_value   = '0;
        s_sample_time_ms = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty query, extreme samples, a gap too short to accept,
        // then an accepted peak that starts the refractory count.
        send_item(OP_QUERY, 24'h000000, 32'h0);
        send_item(OP_SAMPLE, 24'h7FFFFF, 32'd100);
        send_item(OP_SAMPLE, 24'h800000, 32'd200);
        send_item(OP_SAMPLE, 24'd5000, 32'd1000);
        send_item(OP_SAMPLE, 24'd6000, 32'd1100);
        send_item(OP_SAMPLE, 24'h800000, 32'd1200);
        send_item(OP_SAMPLE, 24'h7FFFFF, 32'd1300);
        send_item(OP_QUERY, 24'hFFFFFF, 32'hFFFFFFFF);

        // Directed: no refractory, wide limits; wrap of the timestamp,
        // saturation, an out-of-limit report, then a ready query.
        set_config(24'd0, 16'd0, 16'd65535, 16'd0);
        send_item(OP_SAMPLE, 24'd9000, 32'hFFFF_FF00);
        send_item(OP_SAMPLE, 24'h800000, 32'hFFFF_FF10);
        send_item(OP_SAMPLE, 24'd9000, 32'h0000_0100);
        send_item(OP_SAMPLE, 24'h800000, 32'h0000_0110);
        send_item(OP_SAMPLE, 24'd9000, 32'h0002_0000);
        send_item(OP_SAMPLE, 24'h800000, 32'h0002_0010);
        send_item(OP_QUERY, 24'h0, 32'h0);
        write_reg(REG_MAX_INT, 32'd100);
        send_item(OP_SAMPLE, 24'd9000, 32'h0002_1000);
        send_item(OP_SAMPLE, 24'h800000, 32'h0002_1010);
        send_item(OP_QUERY, 24'h0, 32'h0);

        // Random phases over a spread of settings, extremes included.
        set_config(24'd0, 16'd250, 16'd1600, 16'd1);
        run_phase(70);
        set_config(24'h800000, 16'd0, 16'd65535, 16'd0);
        run_phase(50);
        set_config(24'h7FFFFF, 16'd65535, 16'd0, 16'd2);
        run_phase(40);
        set_config(24'($urandom_range(0, 2000)) - 24'd1000, 16'($urandom_range(0, 400)),
                   16'($urandom_range(600, 3000)), 16'($urandom_range(0, 3)));
        hold_req = 1;
        run_phase(80);
        no_idle = 1;
        set_config(24'd500, 16'd100, 16'd1500, 16'd0);
        run_phase(70);
        no_idle = 0;
        step_lo = 1;
        step_hi = 60000;
        set_config(24'hFFFC18, 16'd1000, 16'd65535, 16'd1);
        run_phase(60);
        step_lo = 50;
        step_hi = 250;
        set_config(24'd0, 16'd0, 16'd2000, 16'd65535);
        run_phase(30);

        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
